@@ design/bhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared codes, widths and defaults for the binary-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_KEY_BITS = 32;
  localparam int DEF_TAG_BITS = 32;

  localparam int FIELD_BITS    = 32;
  localparam int CMD_BITS      = 2;
  localparam int STATUS_BITS   = 2;
  localparam int COUNT_BITS    = 11;
  localparam int IN_DATA_BITS  = 2 * FIELD_BITS;
  localparam int OUT_RAW_BITS  = 2 * FIELD_BITS + COUNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_PEEK   = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_TOP,
    S_DOWN,
    S_PLACE,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ design/bhpq_store.sv @@
// ----------------------------------------------------------------------------
// bhpq_store
// Heap entry memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr0,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr1,
  output logic      [WIDTH-1:0]           rdata0,
  output logic      [WIDTH-1:0]           rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

@@ design/binary_heap_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Binary-heap priority queue over an entry memory with registered reads.
// ----------------------------------------------------------------------------
// Input words (s_axis): tuser carries the command (insert, pop, peek), tdata
// carries key and tag. Output words (m_axis): tuser carries the status,
// tdata carries popped/peeked key and tag and the entry count afterwards.
// cfg_data selects the order (1: largest key first); write only when idle.
// One command is in flight at a time. s_axis_tready is high while idle.
// Path from acceptance to m_axis_tvalid, by command:
//   empty/full/unknown command, insert into an empty heap: S_FINISH
//   peek, or a pop that leaves at most one entry: S_TOP, S_FINISH
//   insert: S_UP per level compared (S_PLACE at the root), S_FINISH
//   pop: S_TOP, S_DOWN per level compared (S_PLACE at a leaf), S_FINISH
// Each heap level is one memory read/compare/write step; the sift loop
// runs over up to log2(CAPACITY) levels, and the block returns to
// S_IDLE before the next command is taken.
// A finished result sits in the output register; the next command is
// accepted while it waits, and that command holds in its last step until
// the receiver takes the earlier word. Reset empties the queue, selects
// smallest-first and drops any pending output word. Memory contents are not
// cleared; only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue_core #(
  parameter int CAPACITY = bhpq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = bhpq_pkg::DEF_KEY_BITS,
  parameter int TAG_BITS = bhpq_pkg::DEF_TAG_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_data,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [31:0] key, [63:32] tag
  input  wire logic [bhpq_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // [1:0] cmd
  input  wire logic [bhpq_pkg::CMD_BITS-1:0]        s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [31:0] out_key, [63:32] out_tag, [74:64] count, rest zero
  output logic      [bhpq_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // [1:0] status
  output logic      [bhpq_pkg::STATUS_BITS-1:0]     m_axis_tuser
);

  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int EW = KEY_BITS + TAG_BITS;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;

  logic                   largest_first;
  logic [KEY_BITS-1:0]    hold_key;
  logic [TAG_BITS-1:0]    hold_tag;
  logic [AW-1:0]          pos;
  logic [CW-1:0]          cnt;
  logic                   is_pop;
  logic [STATUS_BITS-1:0] res_status;
  logic [KEY_BITS-1:0]    res_key;
  logic [TAG_BITS-1:0]    res_tag;

  logic                we;
  logic [AW-1:0]       waddr, raddr0, raddr1;
  logic [EW-1:0]       wdata, rdata0, rdata1;

  logic                accept, out_free;
  logic [KEY_BITS-1:0] in_key, rd0_key, rd1_key;
  logic [TAG_BITS-1:0] in_tag, rd0_tag;
  logic [CMD_BITS-1:0] in_cmd;
  logic [AW-1:0]       parent, gparent;
  logic [CW-1:0]       cnt_dec;
  logic [XW-1:0]       cnt_x, left_p, right_p, left_k, right_k;
  logic                up_win, r_beats_l, hold_beats_l, hold_beats_r;
  logic                right_ok, pick_right, hold_wins, pick_has_child;
  logic [AW-1:0]       pick_idx;
  logic [EW-1:0]       pick_entry;

  bhpq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign in_cmd  = s_axis_tuser;
  assign in_key  = s_axis_tdata[KEY_BITS-1:0];
  assign in_tag  = s_axis_tdata[FIELD_BITS+TAG_BITS-1:FIELD_BITS];
  assign rd0_key = rdata0[KEY_BITS-1:0];
  assign rd0_tag = rdata0[EW-1:KEY_BITS];
  assign rd1_key = rdata1[KEY_BITS-1:0];

  assign parent  = (pos - AW'(1)) >> 1;
  assign gparent = (parent - AW'(1)) >> 1;
  assign cnt_dec = cnt - CW'(1);
  assign cnt_x   = XW'(cnt);
  assign left_p  = {1'b0, pos, 1'b1};
  assign right_p = left_p + XW'(1);

  // strict order compares
  assign up_win       = largest_first ? (hold_key > rd0_key) : (hold_key < rd0_key);
  assign r_beats_l    = largest_first ? (rd1_key > rd0_key) : (rd1_key < rd0_key);
  assign hold_beats_l = largest_first ? (hold_key > rd0_key) : (hold_key < rd0_key);
  assign hold_beats_r = largest_first ? (hold_key > rd1_key) : (hold_key < rd1_key);

  assign right_ok       = right_p < cnt_x;
  assign pick_right     = right_ok && r_beats_l;
  assign pick_idx       = pick_right ? right_p[AW-1:0] : left_p[AW-1:0];
  assign pick_entry     = pick_right ? rdata1 : rdata0;
  assign hold_wins      = pick_right ? hold_beats_r : hold_beats_l;
  assign left_k         = {1'b0, pick_idx, 1'b1};
  assign right_k        = left_k + XW'(1);
  assign pick_has_child = left_k < cnt_x;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_INSERT) begin
            if (cnt == CAP_C || cnt == '0) begin
              state_next = S_FINISH;
            end else begin
              state_next = S_UP;
            end
          end else if (in_cmd == CMD_POP || in_cmd == CMD_PEEK) begin
            state_next = (cnt == '0) ? S_FINISH : S_TOP;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_UP: begin
        if (up_win && parent != '0) begin
          state_next = S_UP;
        end else if (up_win) begin
          state_next = S_PLACE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_TOP: begin
        if (is_pop && cnt_dec > CW'(1)) begin
          state_next = S_DOWN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DOWN: begin
        if (hold_wins) begin
          state_next = S_FINISH;
        end else if (pick_has_child) begin
          state_next = S_DOWN;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE:  state_next = S_FINISH;
      S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    we     = 1'b0;
    waddr  = pos;
    wdata  = {hold_tag, hold_key};
    raddr0 = parent;
    raddr1 = '0;
    case (state)
      S_IDLE: begin
        if (accept && in_cmd == CMD_INSERT && cnt != CAP_C) begin
          if (cnt == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {in_tag, in_key};
          end else begin
            raddr0 = AW'((cnt - CW'(1)) >> 1);
          end
        end else begin
          raddr0 = '0;
          raddr1 = AW'(cnt_dec);
        end
      end
      S_UP: begin
        we = 1'b1;
        if (up_win) begin
          wdata  = rdata0;
          raddr0 = gparent;
        end
      end
      S_TOP: begin
        raddr0 = AW'(1);
        raddr1 = (cnt_dec > CW'(2)) ? AW'(2) : AW'(1);
        if (is_pop && cnt_dec == CW'(1)) begin
          we    = 1'b1;
          waddr = '0;
          wdata = rdata1;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (!hold_wins) begin
          wdata  = pick_entry;
          raddr0 = left_k[AW-1:0];
          raddr1 = (right_k < cnt_x) ? right_k[AW-1:0] : left_k[AW-1:0];
        end
      end
      S_PLACE: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      largest_first <= 1'b0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        largest_first <= cfg_data;
      end
      if (state == S_IDLE && accept && in_cmd == CMD_INSERT && cnt != CAP_C) begin
        cnt <= cnt + CW'(1);
      end else if (state == S_TOP && is_pop) begin
        cnt <= cnt_dec;
      end
      if (state == S_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          hold_key <= in_key;
          hold_tag <= in_tag;
          pos      <= AW'(cnt);
          is_pop   <= (in_cmd == CMD_POP);
          res_key  <= '0;
          res_tag  <= '0;
          if (in_cmd == CMD_INSERT) begin
            res_status <= (cnt == CAP_C) ? STATUS_FULL : STATUS_OK;
          end else if (in_cmd == CMD_POP || in_cmd == CMD_PEEK) begin
            res_status <= (cnt == '0) ? STATUS_EMPTY : STATUS_OK;
          end else begin
            res_status <= STATUS_OK;
          end
        end
      end
      S_UP: begin
        if (up_win) begin
          pos <= parent;
        end
      end
      S_TOP: begin
        res_key  <= rd0_key;
        res_tag  <= rd0_tag;
        hold_key <= rdata1[KEY_BITS-1:0];
        hold_tag <= rdata1[EW-1:KEY_BITS];
        pos      <= '0;
      end
      S_DOWN: begin
        if (!hold_wins) begin
          pos <= pick_idx;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          m_axis_tuser <= res_status;
          m_axis_tdata <= OUT_DATA_BITS'({COUNT_BITS'(cnt), FIELD_BITS'(res_tag),
                                          FIELD_BITS'(res_key)});
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/bhpq_checker.sv @@
// ----------------------------------------------------------------------------
// bhpq_checker
// Port-level checks on the priority queue core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 s_axis_tready,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [bhpq_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  input wire logic [bhpq_pkg::STATUS_BITS-1:0]     m_axis_tuser
);

  import bhpq_pkg::*;

  // reset leaves the block idle with no word pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (s_axis_tready && !m_axis_tvalid))
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word dropped while stalled");

  // a rejected insert returns no entry
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == STATUS_FULL) |-> (m_axis_tdata[2*FIELD_BITS-1:0] == '0))
    else $error("full status with nonzero entry");

  // empty status means nothing held
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == STATUS_EMPTY) |->
      (m_axis_tdata[OUT_RAW_BITS-1:0] == '0))
    else $error("empty status with nonzero entry or count");

endmodule

bind binary_heap_priority_queue_core bhpq_checker u_bhpq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
